// ===== design/cts_pkg.sv =====
// shared types, constants and helper functions for the calendar timestamp converter
// depends on nothing; imported by all rtl modules and by the checker and testbench
`timescale 1ns / 1ps
`default_nettype none

package cts_pkg;

	localparam int PIPE_DEPTH = 9;

	localparam logic [50:0] STAMP_MAX  = 51'd2068116364799999;
	localparam logic [26:0] MS_PER_DAY = 27'd86400000;

	// reciprocals for constant division
	localparam logic [25:0] RECIP_DAY  = 26'd52124995;    // 2^52 / 86400000
	localparam logic [31:0] RECIP_YEAR = 32'd3010360589;  // 400 * 2^40 / 146097
	localparam logic [27:0] RECIP_1000 = 28'd137438954;   // 2^37 / 1000, rounded up
	localparam logic [17:0] RECIP_60   = 18'd139811;      // 2^23 / 60, rounded up
	localparam logic [16:0] RECIP_100  = 17'd83887;       // 2^23 / 100, rounded up

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_FIELDS = 2'd1;
	localparam logic [1:0] ST_CLAMPED    = 2'd2;

	typedef logic [PIPE_DEPTH-1:0] stage_en_t;

	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  milli;
	} fields_t;

	// floor(x / 100) for x below 91180
	function automatic logic [9:0] div100(input logic [16:0] x);
		logic [33:0] p;
		p = 34'(x) * 34'(RECIP_100);
		return p[32:23];
	endfunction

	// q100 = ceil(c / 100), q400 = ceil(c / 400)
	function automatic logic is_leap(input logic [16:0] c, input logic [9:0] q100,
			input logic [9:0] q400);
		logic div4;
		logic div100_n;
		logic div400;
		div4     = (c[1:0] == 2'd0);
		div100_n = ((17'(q100) * 17'd100) != c);
		div400   = ((17'(q400) * 17'd400) == c);
		return div4 && (div100_n || div400);
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== design/cts_if.sv =====
// valid/ready channel interfaces for command and response beats
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface cts_cmd_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic        [15:0] year_in;
	logic        [3:0]  month_in;
	logic        [4:0]  day_in;
	logic        [4:0]  hour_in;
	logic        [5:0]  minute_in;
	logic        [5:0]  second_in;
	logic        [9:0]  milli_in;
	logic signed [63:0] stamp_in;

	modport source (output valid, op, year_in, month_in, day_in, hour_in, minute_in,
		second_in, milli_in, stamp_in, input ready);
	modport sink (input valid, op, year_in, month_in, day_in, hour_in, minute_in,
		second_in, milli_in, stamp_in, output ready);
endinterface

interface cts_rsp_if;
	logic        valid;
	logic        ready;
	logic [50:0] stamp_out;
	logic [15:0] year_out;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [4:0]  hour_out;
	logic [5:0]  minute_out;
	logic [5:0]  second_out;
	logic [9:0]  milli_out;
	logic [1:0]  status;

	modport source (output valid, stamp_out, year_out, month_out, day_out, hour_out,
		minute_out, second_out, milli_out, status, input ready);
	modport sink (input valid, stamp_out, year_out, month_out, day_out, hour_out,
		minute_out, second_out, milli_out, status, output ready);
endinterface

`default_nettype wire

// ===== design/cts_encode.sv =====
// encode datapath: calendar fields to millisecond count, three working stages
// then a delay line to the common pipeline depth; depends on cts_pkg
`timescale 1ns / 1ps
`default_nettype none

module cts_encode (
	input  wire logic              clk,
	input  wire cts_pkg::stage_en_t en,
	input  wire logic [15:0]       year_in,
	input  wire logic [3:0]        month_in,
	input  wire logic [4:0]        day_in,
	input  wire logic [4:0]        hour_in,
	input  wire logic [5:0]        minute_in,
	input  wire logic [5:0]        second_in,
	input  wire logic [9:0]        milli_in,
	output logic      [50:0]       stamp,
	output logic                   bad
);
	import cts_pkg::*;

	logic [15:0] year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [24:0] y365_s1;
	logic [14:0] q4_s1;
	logic [9:0]  q100_s1;
	logic [9:0]  q400_s1;
	logic [26:0] tod_s1;
	logic        fok_s1;

	logic [24:0] days_s2;
	logic [26:0] tod_s2;
	logic        ok_s2;

	logic [50:0] stamp_sk [2:PIPE_DEPTH-1];
	logic        bad_sk   [2:PIPE_DEPTH-1];

	logic [16:0] y_ext;
	logic        leap;
	logic [4:0]  mlen;
	logic [24:0] days;
	logic [51:0] total;

	assign y_ext = {1'b0, year_s1};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			year_s1  <= year_in;
			month_s1 <= month_in;
			day_s1   <= day_in;
			y365_s1  <= 25'(25'(year_in) * 25'd365);
			q4_s1    <= 15'((17'(year_in) + 17'd3) >> 2);
			q100_s1  <= div100(17'(year_in) + 17'd99);
			q400_s1  <= div100(17'((17'(year_in) + 17'd399) >> 2));
			tod_s1   <= 27'(27'(hour_in) * 27'd3600000 + 27'(minute_in) * 27'd60000 +
				27'(second_in) * 27'd1000 + 27'(milli_in));
			fok_s1   <= (month_in >= 4'd1) && (month_in <= 4'd12) && (day_in >= 5'd1) &&
				(hour_in <= 5'd23) && (minute_in <= 6'd59) && (second_in <= 6'd59) &&
				(milli_in <= 10'd999);
		end
	end

	always_comb begin
		leap = is_leap(y_ext, q100_s1, q400_s1);
		case (month_s1) inside
			4'd2:                      mlen = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   mlen = 5'd30;
			default:                   mlen = 5'd31;
		endcase
		days = 25'(y365_s1 + 25'(q4_s1) - 25'(q100_s1) + 25'(q400_s1) +
			25'(month_start(month_s1)) + 25'(leap && (month_s1 > 4'd2)) + 25'(day_s1) -
			25'd1);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			days_s2 <= days;
			tod_s2  <= tod_s1;
			ok_s2   <= fok_s1 && (day_s1 <= mlen);
		end
	end

	assign total = 52'(days_s2) * 52'(MS_PER_DAY) + 52'(tod_s2);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			stamp_sk[2] <= ok_s2 ? total[50:0] : '0;
			bad_sk[2]   <= !ok_s2;
		end
	end

	for (genvar k = 3; k < PIPE_DEPTH; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en[k]) begin
				stamp_sk[k] <= stamp_sk[k-1];
				bad_sk[k]   <= bad_sk[k-1];
			end
		end
	end

	assign stamp = stamp_sk[PIPE_DEPTH-1];
	assign bad   = bad_sk[PIPE_DEPTH-1];

endmodule

`default_nettype wire

// ===== design/cts_decode.sv =====
// decode datapath: clamp, day split, time-of-day split, year search over four
// candidates, month split; nine stages; depends on cts_pkg
`timescale 1ns / 1ps
`default_nettype none

module cts_decode (
	input  wire logic               clk,
	input  wire cts_pkg::stage_en_t en,
	input  wire logic signed [63:0] stamp_in,
	output logic             [50:0] stamp,
	output logic                    clamp,
	output cts_pkg::fields_t        fields
);
	import cts_pkg::*;

	// stage 1
	logic [50:0] t_s1;
	logic        clamp_s1;
	// stage 2
	logic [50:0] t_s2;
	logic        clamp_s2;
	logic [24:0] q0_s2;
	// stage 3
	logic [50:0] t_s3;
	logic        clamp_s3;
	logic [24:0] q0_s3;
	logic [50:0] p_s3;
	// stage 4
	logic [50:0] t_s4;
	logic        clamp_s4;
	logic [24:0] dn_s4;
	logic [26:0] msday_s4;
	// stage 5
	logic [50:0] t_s5;
	logic        clamp_s5;
	logic [24:0] dn_s5;
	logic [15:0] y0_s5;
	logic [26:0] msday_s5;
	logic [16:0] sec_s5;
	// stage 6
	logic [50:0] t_s6;
	logic        clamp_s6;
	logic [24:0] dn_s6;
	logic [16:0] c_s6    [4];
	logic [24:0] c365_s6 [4];
	logic [9:0]  q100_s6 [4];
	logic [9:0]  q400_s6 [4];
	logic [16:0] sec_s6;
	logic [10:0] min_s6;
	logic [9:0]  milli_s6;
	// stage 7
	logic [50:0] t_s7;
	logic        clamp_s7;
	logic [24:0] dn_s7;
	logic [16:0] c_s7    [4];
	logic [24:0] dby_s7  [4];
	logic        leap_s7 [4];
	logic [10:0] min_s7;
	logic [4:0]  hour_s7;
	logic [5:0]  second_s7;
	logic [9:0]  milli_s7;
	// stage 8
	logic [50:0] t_s8;
	logic        clamp_s8;
	logic [15:0] year_s8;
	logic [8:0]  doy_s8;
	logic        leap_s8;
	logic [4:0]  hour_s8;
	logic [5:0]  minute_s8;
	logic [5:0]  second_s8;
	logic [9:0]  milli_s8;
	// stage 9
	logic [50:0] t_s9;
	logic        clamp_s9;
	fields_t     fields_s9;

	logic [56:0] day_prod;
	logic [51:0] day_ms;
	logic [50:0] rem_full;
	logic [27:0] rem;
	logic        fix;
	logic [56:0] yr_prod;
	logic [54:0] sec_prod;
	logic [26:0] milli_full;
	logic [34:0] min_prod;
	logic [16:0] cand [4];
	logic [16:0] sec_rem;
	logic [28:0] hour_prod;
	logic [1:0]  sel;
	logic [10:0] min_rem;
	logic [3:0]  mon;
	logic [8:0]  thr;
	logic [8:0]  th;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			if (stamp_in[63]) begin
				t_s1     <= '0;
				clamp_s1 <= 1'b1;
			end else if (stamp_in[62:0] > {12'd0, STAMP_MAX}) begin
				t_s1     <= STAMP_MAX;
				clamp_s1 <= 1'b1;
			end else begin
				t_s1     <= stamp_in[50:0];
				clamp_s1 <= 1'b0;
			end
		end
	end

	assign day_prod = 57'(t_s1[50:20]) * 57'(RECIP_DAY);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			t_s2     <= t_s1;
			clamp_s2 <= clamp_s1;
			q0_s2    <= day_prod[56:32];
		end
	end

	assign day_ms = 52'(q0_s2) * 52'(MS_PER_DAY);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			t_s3     <= t_s2;
			clamp_s3 <= clamp_s2;
			q0_s3    <= q0_s2;
			p_s3     <= day_ms[50:0];
		end
	end

	// estimate is at most one day low
	always_comb begin
		rem_full = t_s3 - p_s3;
		rem      = rem_full[27:0];
		fix      = (rem >= {1'b0, MS_PER_DAY});
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			t_s4     <= t_s3;
			clamp_s4 <= clamp_s3;
			dn_s4    <= q0_s3 + 25'(fix);
			msday_s4 <= fix ? 27'(rem - {1'b0, MS_PER_DAY}) : rem[26:0];
		end
	end

	assign yr_prod  = 57'(dn_s4) * 57'(RECIP_YEAR);
	assign sec_prod = 55'(msday_s4) * 55'(RECIP_1000);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			t_s5     <= t_s4;
			clamp_s5 <= clamp_s4;
			dn_s5    <= dn_s4;
			y0_s5    <= yr_prod[55:40];
			msday_s5 <= msday_s4;
			sec_s5   <= sec_prod[53:37];
		end
	end

	// year lies within one below to two above the estimate
	always_comb begin
		cand[0]    = (y0_s5 == 16'd0) ? 17'd0 : {1'b0, y0_s5} - 17'd1;
		cand[1]    = {1'b0, y0_s5};
		cand[2]    = {1'b0, y0_s5} + 17'd1;
		cand[3]    = {1'b0, y0_s5} + 17'd2;
		milli_full = msday_s5 - 27'(sec_s5) * 27'd1000;
		min_prod   = 35'(sec_s5) * 35'(RECIP_60);
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			t_s6     <= t_s5;
			clamp_s6 <= clamp_s5;
			dn_s6    <= dn_s5;
			sec_s6   <= sec_s5;
			min_s6   <= min_prod[33:23];
			milli_s6 <= milli_full[9:0];
			for (int k = 0; k < 4; k++) begin
				c_s6[k]    <= cand[k];
				c365_s6[k] <= 25'(25'(cand[k]) * 25'd365);
				q100_s6[k] <= div100(cand[k] + 17'd99);
				q400_s6[k] <= div100(17'((cand[k] + 17'd399) >> 2));
			end
		end
	end

	always_comb begin
		sec_rem   = sec_s6 - 17'(min_s6) * 17'd60;
		hour_prod = 29'(min_s6) * 29'(RECIP_60);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			t_s7      <= t_s6;
			clamp_s7  <= clamp_s6;
			dn_s7     <= dn_s6;
			min_s7    <= min_s6;
			hour_s7   <= hour_prod[27:23];
			second_s7 <= sec_rem[5:0];
			milli_s7  <= milli_s6;
			for (int k = 0; k < 4; k++) begin
				c_s7[k]    <= c_s6[k];
				dby_s7[k]  <= 25'(c365_s6[k] + 25'((c_s6[k] + 17'd3) >> 2) -
					25'(q100_s6[k]) + 25'(q400_s6[k]));
				leap_s7[k] <= is_leap(c_s6[k], q100_s6[k], q400_s6[k]);
			end
		end
	end

	always_comb begin
		sel = 2'd0;
		for (int k = 1; k < 4; k++) begin
			if (dby_s7[k] <= dn_s7) begin
				sel = 2'(k);
			end
		end
		min_rem = min_s7 - 11'(hour_s7) * 11'd60;
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			t_s8      <= t_s7;
			clamp_s8  <= clamp_s7;
			year_s8   <= c_s7[sel][15:0];
			doy_s8    <= 9'(dn_s7 - dby_s7[sel]);
			leap_s8   <= leap_s7[sel];
			hour_s8   <= hour_s7;
			minute_s8 <= min_rem[5:0];
			second_s8 <= second_s7;
			milli_s8  <= milli_s7;
		end
	end

	always_comb begin
		mon = 4'd1;
		thr = 9'd0;
		for (int m = 2; m <= 12; m++) begin
			th = month_start(4'(m)) + 9'(leap_s8 && (m > 2));
			if (doy_s8 >= th) begin
				mon = 4'(m);
				thr = th;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			t_s9             <= t_s8;
			clamp_s9         <= clamp_s8;
			fields_s9.year   <= year_s8;
			fields_s9.month  <= mon;
			fields_s9.day    <= 5'(doy_s8 - thr + 9'd1);
			fields_s9.hour   <= hour_s8;
			fields_s9.minute <= minute_s8;
			fields_s9.second <= second_s8;
			fields_s9.milli  <= milli_s8;
		end
	end

	assign stamp  = t_s9;
	assign clamp  = clamp_s9;
	assign fields = fields_s9;

endmodule

`default_nettype wire

// ===== design/calendar_timestamp_converter_unit.sv =====
// both operations run through all PIPE_DEPTH stages from command to response beat
// throughput: one beat per cycle; each stage stalls only when it is full and the
// stage after it holds, so bubbles are squeezed out under backpressure
// reset: arst_n clears all stage valid bits; datapath registers are not reset
// depends on cts_pkg, cts_if, cts_encode and cts_decode
`timescale 1ns / 1ps
`default_nettype none

module calendar_timestamp_converter_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cts_cmd_if.sink    cmd,
	cts_rsp_if.source  rsp
);
	import cts_pkg::*;

	logic [PIPE_DEPTH-1:0] vld_s;
	logic [PIPE_DEPTH-1:0] op_s;
	stage_en_t             en;

	logic [50:0] enc_stamp;
	logic        enc_bad;
	logic [50:0] dec_stamp;
	logic        dec_clamp;
	fields_t     dec_fields;
	logic        last_dec;

	always_comb begin
		en[PIPE_DEPTH-1] = !vld_s[PIPE_DEPTH-1] || rsp.ready;
		for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= cmd.valid;
			end
			for (int k = 1; k < PIPE_DEPTH; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			op_s[0] <= cmd.op;
		end
		for (int k = 1; k < PIPE_DEPTH; k++) begin
			if (en[k]) begin
				op_s[k] <= op_s[k-1];
			end
		end
	end

	cts_encode u_enc (
		.clk       (clk),
		.en        (en),
		.year_in   (cmd.year_in),
		.month_in  (cmd.month_in),
		.day_in    (cmd.day_in),
		.hour_in   (cmd.hour_in),
		.minute_in (cmd.minute_in),
		.second_in (cmd.second_in),
		.milli_in  (cmd.milli_in),
		.stamp     (enc_stamp),
		.bad       (enc_bad)
	);

	cts_decode u_dec (
		.clk      (clk),
		.en       (en),
		.stamp_in (cmd.stamp_in),
		.stamp    (dec_stamp),
		.clamp    (dec_clamp),
		.fields   (dec_fields)
	);

	assign cmd.ready = en[0];
	assign rsp.valid = vld_s[PIPE_DEPTH-1];
	assign last_dec  = (op_s[PIPE_DEPTH-1] == OP_DECODE);

	always_comb begin
		if (last_dec) begin
			rsp.stamp_out  = dec_stamp;
			rsp.year_out   = dec_fields.year;
			rsp.month_out  = dec_fields.month;
			rsp.day_out    = dec_fields.day;
			rsp.hour_out   = dec_fields.hour;
			rsp.minute_out = dec_fields.minute;
			rsp.second_out = dec_fields.second;
			rsp.milli_out  = dec_fields.milli;
			rsp.status     = dec_clamp ? ST_CLAMPED : ST_OK;
		end else begin
			rsp.stamp_out  = enc_stamp;
			rsp.year_out   = '0;
			rsp.month_out  = '0;
			rsp.day_out    = '0;
			rsp.hour_out   = '0;
			rsp.minute_out = '0;
			rsp.second_out = '0;
			rsp.milli_out  = '0;
			rsp.status     = enc_bad ? ST_BAD_FIELDS : ST_OK;
		end
	end

`ifndef SYNTHESIS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_BAD_FIELDS) |-> (rsp.stamp_out == '0))
		else $error("invalid encode beat with nonzero stamp");

	a_stamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.stamp_out <= STAMP_MAX))
		else $error("stamp above maximum");

	a_dec_date: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && last_dec |-> (rsp.month_out >= 4'd1) && (rsp.month_out <= 4'd12) &&
		(rsp.day_out >= 5'd1) && (rsp.hour_out <= 5'd23) && (rsp.minute_out <= 6'd59) &&
		(rsp.second_out <= 6'd59) && (rsp.milli_out <= 10'd999))
		else $error("decoded fields out of range");

	a_enc_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !last_dec |-> (rsp.status == ST_OK) || (rsp.status == ST_BAD_FIELDS))
		else $error("encode beat with decode status");
`endif

endmodule

`default_nettype wire

// ===== dv/cts_checker.sv =====
// checker for the calendar timestamp converter: predicts each response from the command beat
// and compares it field by field; depends on cts_pkg and cts_if
`timescale 1ns / 1ps

module cts_checker (
	input  logic      clk,
	input  logic      arst_n,
	cts_cmd_if.sink   cmd_mon,
	cts_rsp_if.sink   rsp_mon,
	output int        fail_count,
	output int        pending,
	output int        n_encode,
	output int        n_decode,
	output int        n_bad
);
	import cts_pkg::*;

	typedef struct packed {
		logic [50:0] stamp;
		fields_t     f;
		logic [1:0]  st;
	} conv_result_t;

	conv_result_t conv_q[$];

	function automatic bit leap_year(longint unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic longint unsigned days_to_year(longint unsigned y);
		return y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	function automatic longint unsigned days_to_month(longint unsigned y, longint unsigned m);
		longint unsigned cum[12];
		longint unsigned d;
		cum = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
		d = cum[(m - 1) % 12];
		if (m > 2 && leap_year(y))
			d++;
		return d;
	endfunction

	function automatic longint unsigned days_in_month(longint unsigned y, longint unsigned m);
		if (m == 2)
			return leap_year(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		if (m >= 1 && m <= 12)
			return 31;
		return 0;
	endfunction

	function automatic conv_result_t convert(logic op, fields_t fi, logic signed [63:0] raw);
		conv_result_t r;
		longint unsigned t, dn, y, mo;
		bit ok;
		r = '0;
		if (op == OP_ENCODE) begin
			ok = fi.month >= 1 && fi.month <= 12 && fi.day >= 1 && fi.hour <= 23 &&
				fi.minute <= 59 && fi.second <= 59 && fi.milli <= 999 &&
				fi.day <= days_in_month(fi.year, fi.month);
			if (ok) begin
				t = days_to_year(fi.year) + days_to_month(fi.year, fi.month) + fi.day - 1;
				t = (((t * 24 + fi.hour) * 60 + fi.minute) * 60 + fi.second) * 1000 + fi.milli;
				r.stamp = t[50:0];
			end else begin
				r.st = ST_BAD_FIELDS;
			end
			return r;
		end
		if (raw < 0) begin
			t = 0;
			r.st = ST_CLAMPED;
		end else if (raw > 64'(STAMP_MAX)) begin
			t = STAMP_MAX;
			r.st = ST_CLAMPED;
		end else begin
			t = raw;
		end
		r.stamp = t[50:0];
		r.f.milli = t % 1000;
		r.f.second = (t / 1000) % 60;
		r.f.minute = (t / 60000) % 60;
		r.f.hour = (t / 3600000) % 24;
		dn = t / 86400000;
		y = (dn * 400) / 146097;
		if (y > 65535)
			y = 65535;
		while (y > 0 && days_to_year(y) > dn)
			y--;
		while (y < 65535 && days_to_year(y + 1) <= dn)
			y++;
		dn -= days_to_year(y);
		mo = 1;
		while (mo < 12 && days_to_month(y, mo + 1) <= dn)
			mo++;
		dn -= days_to_month(y, mo);
		r.f.year = y;
		r.f.month = mo;
		r.f.day = dn + 1;
		return r;
	endfunction

	assign pending = conv_q.size();

	always @(posedge clk or negedge arst_n) begin
		conv_result_t want, got;
		fields_t fi;
		if (!arst_n) begin
			fail_count <= 0;
			n_encode <= 0;
			n_decode <= 0;
			n_bad <= 0;
		end else begin
			if (cmd_mon.valid && cmd_mon.ready) begin
				fi = '{cmd_mon.year_in, cmd_mon.month_in, cmd_mon.day_in, cmd_mon.hour_in,
					cmd_mon.minute_in, cmd_mon.second_in, cmd_mon.milli_in};
				want = convert(cmd_mon.op, fi, cmd_mon.stamp_in);
				conv_q.push_back(want);
				if (cmd_mon.op == OP_ENCODE)
					n_encode <= n_encode + 1;
				else
					n_decode <= n_decode + 1;
				if (want.st != ST_OK)
					n_bad <= n_bad + 1;
			end
			if (rsp_mon.valid && rsp_mon.ready) begin
				got.stamp = rsp_mon.stamp_out;
				got.f = '{rsp_mon.year_out, rsp_mon.month_out, rsp_mon.day_out,
					rsp_mon.hour_out, rsp_mon.minute_out, rsp_mon.second_out,
					rsp_mon.milli_out};
				got.st = rsp_mon.status;
				if (conv_q.size() == 0) begin
					$display("%0t: response beat with nothing expected, got %p", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = conv_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== dv/tb.sv =====
// testbench top for calendar_timestamp_converter_unit: drives command beats with random gaps
// and response stalls; depends on cts_pkg, cts_if, cts_checker and the rtl
`timescale 1ns / 1ps

module tb;
	import cts_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending, n_encode, n_decode, n_bad;
	bit hold_off = 0;

	cts_cmd_if cmd ();
	cts_rsp_if rsp ();

	calendar_timestamp_converter_unit dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	cts_checker chk (.clk(clk), .arst_n(arst_n), .cmd_mon(cmd), .rsp_mon(rsp),
		.fail_count(fail_count), .pending(pending), .n_encode(n_encode),
		.n_decode(n_decode), .n_bad(n_bad));

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	typedef struct {
		logic op;
		fields_t f;
		logic signed [63:0] stamp;
	} cmd_beat_t;

	cmd_beat_t beat_q[$];

	function automatic fields_t rand_fields();
		fields_t f;
		f.year = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(2100, 1800));
		f.month = $urandom_range(1, 12);
		f.day = $urandom_range(1, 31);
		f.hour = $urandom_range(0, 23);
		f.minute = $urandom_range(0, 59);
		f.second = $urandom_range(0, 59);
		f.milli = $urandom_range(0, 999);
		return f;
	endfunction

	function automatic fields_t noisy_fields();
		return '{16'($urandom), 4'($urandom), 5'($urandom), 5'($urandom), 6'($urandom),
			6'($urandom), 10'($urandom)};
	endfunction

	function automatic logic signed [63:0] rand_stamp();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(5))
			0: return v;
			1: return 64'(STAMP_MAX) - 64'($urandom_range(100000));
			2: return 64'(STAMP_MAX) + 64'($urandom_range(100000));
			3: return 64'($urandom_range(100000));
			default: return v % (64'(STAMP_MAX) + 1);
		endcase
	endfunction

	task automatic add(logic op, fields_t f, logic signed [63:0] s);
		cmd_beat_t b;
		b.op = op;
		b.f = f;
		b.stamp = s;
		beat_q.push_back(b);
	endtask

	task automatic build_stimulus();
		fields_t z;
		z = '{16'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0};
		add(OP_ENCODE, z, 0);
		add(OP_ENCODE, '{16'hffff, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999}, 0);
		add(OP_ENCODE, '{16'd2000, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30, 10'd500}, 0);
		add(OP_ENCODE, '{16'd1900, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 10'd0}, 0);
		add(OP_ENCODE, '{16'd2024, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 10'd0}, 0);
		add(OP_ENCODE, '{16'd2023, 4'd4, 5'd31, 5'd0, 6'd0, 6'd0, 10'd0}, 0);
		add(OP_ENCODE, '{16'd2023, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0}, 0);
		add(OP_ENCODE, '{16'd2023, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0}, 0);
		add(OP_ENCODE, '{16'd2023, 4'd15, 5'd0, 5'd31, 6'd63, 6'd63, 10'd1023}, 0);
		add(OP_ENCODE, '{16'd2023, 4'd1, 5'd1, 5'd24, 6'd0, 6'd0, 10'd0}, 0);
		add(OP_ENCODE, '{16'd2023, 4'd1, 5'd1, 5'd0, 6'd60, 6'd0, 10'd0}, 0);
		add(OP_ENCODE, '{16'd2023, 4'd1, 5'd1, 5'd0, 6'd0, 6'd60, 10'd0}, 0);
		add(OP_ENCODE, '{16'd2023, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd1000}, 0);
		add(OP_DECODE, '1, 0);
		add(OP_DECODE, z, 64'(STAMP_MAX));
		add(OP_DECODE, z, 64'(STAMP_MAX) + 1);
		add(OP_DECODE, z, -1);
		add(OP_DECODE, z, 64'sh8000_0000_0000_0000);
		add(OP_DECODE, z, 64'sh7fff_ffff_ffff_ffff);
		add(OP_DECODE, z, 64'd86399999);
		add(OP_DECODE, z, 64'd31622400000);
		add(OP_DECODE, z, 64'd63113904000000);
		for (int i = 0; i < 1050; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: add(OP_ENCODE, rand_fields(), {$urandom, $urandom});
				4: add(OP_ENCODE, noisy_fields(), {$urandom, $urandom});
				default: add(OP_DECODE, noisy_fields(), rand_stamp());
			endcase
		end
	endtask

	// long receiver hold-off while commands keep coming
	initial begin
		repeat (300) @(posedge clk);
		hold_off = 1;
		repeat (60) @(posedge clk);
		hold_off = 0;
	end

	// receiver waits a drawn number of cycles after each accepted beat
	initial begin
		int gap;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		gap = $urandom_range(3) == 0 ? 0 : $urandom_range(0, 7);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				gap = $urandom_range(3) == 0 ? 0 : $urandom_range(0, 7);
			if (gap != 0) begin
				rsp.ready <= 1'b0;
				gap--;
			end else begin
				rsp.ready <= !hold_off;
			end
		end
	end

	initial begin
		cmd_beat_t b;
		int gap;
		cmd.valid = 1'b0;
		cmd.op = OP_ENCODE;
		cmd.year_in = '0;
		cmd.month_in = '0;
		cmd.day_in = '0;
		cmd.hour_in = '0;
		cmd.minute_in = '0;
		cmd.second_in = '0;
		cmd.milli_in = '0;
		cmd.stamp_in = '0;
		build_stimulus();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		gap = ($urandom_range(1) == 0) ? 0 : $urandom_range(0, 7);
		while (beat_q.size() > 0) begin
			b = beat_q.pop_front();
			repeat (gap) @(posedge clk);
			cmd.valid <= 1'b1;
			cmd.op <= b.op;
			{cmd.year_in, cmd.month_in, cmd.day_in, cmd.hour_in, cmd.minute_in,
				cmd.second_in, cmd.milli_in} <= b.f;
			cmd.stamp_in <= b.stamp;
			do
				@(posedge clk);
			while (!cmd.ready);
			gap = ($urandom_range(1) == 0) ? 0 : $urandom_range(0, 7);
			if (beat_q.size() == 0 || gap != 0)
				cmd.valid <= 1'b0;
		end
		while (pending != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		$display("ran %0d encode and %0d decode beats, %0d with error status", n_encode,
			n_decode, n_bad);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
design/cts_pkg.sv
design/cts_if.sv
design/cts_encode.sv
design/cts_decode.sv
design/calendar_timestamp_converter_unit.sv
dv/cts_checker.sv
dv/tb.sv
